FILE: rtl/gsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Types and constants shared by the gamepad state conditioner modules.
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_LEFT_DZ  = 3'd0,
      REG_RIGHT_DZ = 3'd1,
      REG_TRIG_THR = 3'd2,
      REG_DZ_EN    = 3'd3,
      REG_RECHECK  = 3'd4
   } reg_index_type;

   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
   localparam logic [7:0]  TRIG_THR_RESET = 8'd30;
   localparam logic        DZ_EN_RESET    = 1'b1;
   localparam logic [7:0]  RECHECK_RESET  = 8'd60;

   localparam logic [15:0] FULL_SCALE = 16'd32767;
   localparam logic [14:0] DZ_FULL    = 15'h7FFF;
   localparam logic signed [15:0] AXIS_MIN = 16'sh8000;
   localparam logic signed [15:0] AXIS_NEG_MAX = -16'sd32767;

   typedef struct packed {
      logic [1:0]         port;
      logic               link_ok;
      logic [15:0]        raw_buttons;
      logic [7:0]         raw_left_trigger;
      logic [7:0]         raw_right_trigger;
      logic signed [15:0] raw_left_x;
      logic signed [15:0] raw_left_y;
      logic signed [15:0] raw_right_x;
      logic signed [15:0] raw_right_y;
   } req_type;

   typedef struct packed {
      logic               sampled;
      logic               is_connected;
      logic               just_inserted;
      logic               just_removed;
      logic [15:0]        pressed_edges;
      logic [1:0]         left_trigger_flags;
      logic [1:0]         right_trigger_flags;
      logic signed [15:0] left_x_out;
      logic signed [15:0] left_y_out;
      logic signed [15:0] right_x_out;
      logic signed [15:0] right_y_out;
      logic               activity;
   } rsp_type;

   typedef struct packed {
      logic        connected;
      logic [8:0]  countdown;
      logic [15:0] prev_buttons;
      logic        left_held;
      logic        right_held;
   } entry_type;

   typedef struct packed {
      logic        enable;
      logic [14:0] dead_zone;
   } stick_cfg_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_READ,
      T_CALC,
      T_RESULT
   } top_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQD,
      ST_CMP,
      ST_ROOT,
      ST_DEN,
      ST_NUMX,
      ST_NUMY,
      ST_DIVX,
      ST_DIVY
   } stick_state_type;

endpackage

FILE: rtl/gsc_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_state_mem
// Per-port state memory with registered read and valid bits cleared by reset.
// ----------------------------------------------------------------------------
module gsc_state_mem #(
   parameter int PORTS = 4,
   parameter int AW    = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output gsc_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  gsc_pkg::entry_type  wr_data
);

   gsc_pkg::entry_type mem [PORTS];
   logic [PORTS-1:0]   valid_ff;
   gsc_pkg::entry_type rd_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

FILE: rtl/gsc_stick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_stick
// Radial deadzone with rescale for one stick, or a clipped pass-through when
// disabled; on one shared multiplier, a bit-serial square root and divider.
// ----------------------------------------------------------------------------
module gsc_stick (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  gsc_pkg::stick_cfg_type  cfg,
   input  logic signed [15:0]      x_in,
   input  logic signed [15:0]      y_in,
   output logic                    busy,
   output logic signed [15:0]      x_out,
   output logic signed [15:0]      y_out
);

   gsc_pkg::stick_state_type state_ff, state_in;

   logic [15:0]        ax_ff, ay_ff;
   logic               xneg_ff, yneg_ff;
   logic [14:0]        dz_ff;
   logic [31:0]        sx_ff, sy_ff, s_ff;
   logic [29:0]        dd_ff;
   logic [31:0]        n_ff, root_ff;
   logic [3:0]         cnt_ff;
   logic [15:0]        len_ff;
   logic [30:0]        den_ff;
   logic [31:0]        px_ff, py_ff;
   logic [47:0]        rem_ff;
   logic [15:0]        q_ff;
   logic               ovf_ff;
   logic signed [15:0] xo_ff, yo_ff;

   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   logic [31:0] root_bit, root_try;
   logic        root_ge;
   logic [47:0] trial, num_x, num_y, den_top;
   logic        div_ge;
   logic [15:0] q_in, q_mag;
   logic [15:0] len_minus_dz;

   assign len_minus_dz = len_ff - {1'b0, dz_ff};
   assign busy = state_ff != gsc_pkg::ST_IDLE;
   assign x_out = xo_ff;
   assign y_out = yo_ff;

   always_comb begin
      mul_a = ax_ff;
      mul_b = ax_ff;
      unique case (state_ff)
         gsc_pkg::ST_SQY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         gsc_pkg::ST_SQD: begin
            mul_a = {1'b0, dz_ff};
            mul_b = {1'b0, dz_ff};
         end
         gsc_pkg::ST_DEN: begin
            mul_a = gsc_pkg::FULL_SCALE - {1'b0, dz_ff};
            mul_b = root_ff[15:0];
         end
         gsc_pkg::ST_NUMX: begin
            mul_a = ax_ff;
            mul_b = len_minus_dz;
         end
         gsc_pkg::ST_NUMY: begin
            mul_a = ay_ff;
            mul_b = len_minus_dz;
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      root_bit = 32'd1 << {~cnt_ff, 1'b0};
      root_try = root_ff + root_bit;
      root_ge  = n_ff >= root_try;
      num_x    = {1'b0, px_ff, 15'd0} - {16'd0, px_ff};
      num_y    = {1'b0, py_ff, 15'd0} - {16'd0, py_ff};
      den_top  = {1'b0, den_ff, 16'd0};
      trial    = {17'd0, den_ff} << ~cnt_ff;
      div_ge   = rem_ff >= trial;
      q_in     = {q_ff[14:0], div_ge};
      q_mag    = (ovf_ff || q_in[15]) ? gsc_pkg::FULL_SCALE : q_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsc_pkg::ST_IDLE: begin
            if (start && cfg.enable) begin
               state_in = gsc_pkg::ST_SQX;
            end
         end
         gsc_pkg::ST_SQX: state_in = gsc_pkg::ST_SQY;
         gsc_pkg::ST_SQY: state_in = gsc_pkg::ST_SQD;
         gsc_pkg::ST_SQD: state_in = gsc_pkg::ST_CMP;
         gsc_pkg::ST_CMP: begin
            if (dz_ff == gsc_pkg::DZ_FULL || s_ff <= {2'b0, dd_ff}) begin
               state_in = gsc_pkg::ST_IDLE;
            end else begin
               state_in = gsc_pkg::ST_ROOT;
            end
         end
         gsc_pkg::ST_ROOT: begin
            if (&cnt_ff) begin
               state_in = gsc_pkg::ST_DEN;
            end
         end
         gsc_pkg::ST_DEN:  state_in = gsc_pkg::ST_NUMX;
         gsc_pkg::ST_NUMX: state_in = gsc_pkg::ST_NUMY;
         gsc_pkg::ST_NUMY: state_in = gsc_pkg::ST_DIVX;
         gsc_pkg::ST_DIVX: begin
            if (&cnt_ff) begin
               state_in = gsc_pkg::ST_DIVY;
            end
         end
         gsc_pkg::ST_DIVY: begin
            if (&cnt_ff) begin
               state_in = gsc_pkg::ST_IDLE;
            end
         end
         default: state_in = gsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         gsc_pkg::ST_IDLE: begin
            if (start) begin
               ax_ff   <= x_in[15] ? 16'(~x_in + 16'd1) : x_in;
               ay_ff   <= y_in[15] ? 16'(~y_in + 16'd1) : y_in;
               xneg_ff <= x_in[15];
               yneg_ff <= y_in[15];
               dz_ff   <= cfg.dead_zone;
               if (!cfg.enable) begin
                  xo_ff <= (x_in == gsc_pkg::AXIS_MIN) ? gsc_pkg::AXIS_NEG_MAX : x_in;
                  yo_ff <= (y_in == gsc_pkg::AXIS_MIN) ? gsc_pkg::AXIS_NEG_MAX : y_in;
               end
            end
         end
         gsc_pkg::ST_SQX: sx_ff <= mul_p;
         gsc_pkg::ST_SQY: sy_ff <= mul_p;
         gsc_pkg::ST_SQD: begin
            dd_ff <= mul_p[29:0];
            s_ff  <= sx_ff + sy_ff;
         end
         gsc_pkg::ST_CMP: begin
            xo_ff   <= '0;
            yo_ff   <= '0;
            n_ff    <= s_ff;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         gsc_pkg::ST_ROOT: begin
            if (root_ge) begin
               n_ff    <= n_ff - root_try;
               root_ff <= (root_ff >> 1) + root_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
            cnt_ff <= cnt_ff + 4'd1;
         end
         gsc_pkg::ST_DEN: begin
            len_ff <= root_ff[15:0];
            den_ff <= mul_p[30:0];
         end
         gsc_pkg::ST_NUMX: begin
            px_ff  <= mul_p;
         end
         gsc_pkg::ST_NUMY: begin
            py_ff  <= mul_p;
            rem_ff <= num_x;
            ovf_ff <= num_x >= den_top;
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         gsc_pkg::ST_DIVX: begin
            cnt_ff <= cnt_ff + 4'd1;
            if (&cnt_ff) begin
               xo_ff  <= xneg_ff ? 16'(-q_mag) : q_mag;
               rem_ff <= num_y;
               ovf_ff <= num_y >= den_top;
               q_ff   <= '0;
            end else begin
               q_ff   <= q_in;
               rem_ff <= div_ge ? rem_ff - trial : rem_ff;
            end
         end
         gsc_pkg::ST_DIVY: begin
            q_ff   <= q_in;
            rem_ff <= div_ge ? rem_ff - trial : rem_ff;
            cnt_ff <= cnt_ff + 4'd1;
            if (&cnt_ff) begin
               yo_ff <= yneg_ff ? 16'(-q_mag) : q_mag;
            end
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

endmodule

FILE: rtl/gamepad_state_conditioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_state_conditioner_core
// Per-port controller poll tracking with button edges, trigger flags and
// radial stick deadzones.
//
//   Channel   Direction  Handshake           Payload
//   req       in         req_valid/stall     gsc_pkg::req_type
//   rsp       out        rsp_valid/stall     gsc_pkg::rsp_type
//   csr       in/out     APB psel/penable    32-bit registers at 4*index
//
// A poll that is skipped, out of range or finds the port absent goes from
// the read state straight to the result state. A connected poll waits for
// the stick units: three multiplier steps, a 16-step square root, three more
// multiplier steps and two 16-step divisions. With both sticks inside their
// deadzones only the squares run; with the deadzones disabled none of it does.
// Reset is synchronous and clears all port state at once through valid bits.
// A finished result waits in the output register while the next transfer
// is taken; a stalled result holds the block only when a second one is done.
// ----------------------------------------------------------------------------
module gamepad_state_conditioner_core #(
   parameter int PORTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gsc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gsc_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gsc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gsc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam logic [4:0] PORT_LIMIT = 5'(PORTS);

   gsc_pkg::top_state_type state_ff, state_in;
   gsc_pkg::req_type       item_ff, item_in;
   gsc_pkg::rsp_type       res_ff, res_in, rsp_next, rsp_data_ff;
   logic                   conn_ff, conn_in;
   logic                   rsp_valid_ff;

   logic [14:0] left_dz_ff, right_dz_ff;
   logic [7:0]  trig_thr_ff, recheck_ff;
   logic        dz_en_ff;

   logic               mem_rd, mem_wr, load_rsp, stick_start;
   gsc_pkg::entry_type rd_entry, wr_entry;
   logic [AW-1:0]      rd_addr, wr_addr;
   gsc_pkg::reg_index_type csr_index;
   logic               csr_write;

   gsc_pkg::stick_cfg_type left_cfg, right_cfg;
   logic               left_busy, right_busy;
   logic signed [15:0] lx, ly, rx, ry;

   logic        in_range, was, lnow, rnow;

   assign pready    = 1'b1;
   assign csr_index = gsc_pkg::reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= gsc_pkg::LEFT_DZ_RESET;
         right_dz_ff <= gsc_pkg::RIGHT_DZ_RESET;
         trig_thr_ff <= gsc_pkg::TRIG_THR_RESET;
         dz_en_ff    <= gsc_pkg::DZ_EN_RESET;
         recheck_ff  <= gsc_pkg::RECHECK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gsc_pkg::REG_LEFT_DZ:  left_dz_ff  <= pwdata[14:0];
            gsc_pkg::REG_RIGHT_DZ: right_dz_ff <= pwdata[14:0];
            gsc_pkg::REG_TRIG_THR: trig_thr_ff <= pwdata[7:0];
            gsc_pkg::REG_DZ_EN:    dz_en_ff    <= pwdata[0];
            gsc_pkg::REG_RECHECK:  recheck_ff  <= pwdata[7:0];
            default: begin
               recheck_ff <= recheck_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         gsc_pkg::REG_LEFT_DZ:  prdata = {17'd0, left_dz_ff};
         gsc_pkg::REG_RIGHT_DZ: prdata = {17'd0, right_dz_ff};
         gsc_pkg::REG_TRIG_THR: prdata = {24'd0, trig_thr_ff};
         gsc_pkg::REG_DZ_EN:    prdata = {31'd0, dz_en_ff};
         gsc_pkg::REG_RECHECK:  prdata = {24'd0, recheck_ff};
         default:               prdata = '0;
      endcase
   end

   assign rd_addr = AW'(req_data.port);
   assign wr_addr = AW'(item_ff.port);

   gsc_state_mem #(
      .PORTS (PORTS),
      .AW    (AW)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_entry),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   assign left_cfg  = '{enable: dz_en_ff, dead_zone: left_dz_ff};
   assign right_cfg = '{enable: dz_en_ff, dead_zone: right_dz_ff};

   gsc_stick u_left (
      .clock (clock),
      .reset (reset),
      .start (stick_start),
      .cfg   (left_cfg),
      .x_in  (item_ff.raw_left_x),
      .y_in  (item_ff.raw_left_y),
      .busy  (left_busy),
      .x_out (lx),
      .y_out (ly)
   );

   gsc_stick u_right (
      .clock (clock),
      .reset (reset),
      .start (stick_start),
      .cfg   (right_cfg),
      .x_in  (item_ff.raw_right_x),
      .y_in  (item_ff.raw_right_y),
      .busy  (right_busy),
      .x_out (rx),
      .y_out (ry)
   );

   assign in_range = {3'd0, item_ff.port} < PORT_LIMIT;
   assign was      = rd_entry.connected;
   assign lnow     = item_ff.raw_left_trigger > trig_thr_ff;
   assign rnow     = item_ff.raw_right_trigger > trig_thr_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsc_pkg::T_IDLE: begin
            if (req_valid) begin
               state_in = gsc_pkg::T_READ;
            end
         end
         gsc_pkg::T_READ: begin
            if (in_range && item_ff.link_ok &&
                (rd_entry.connected || rd_entry.countdown[8])) begin
               state_in = gsc_pkg::T_CALC;
            end else begin
               state_in = gsc_pkg::T_RESULT;
            end
         end
         gsc_pkg::T_CALC: begin
            if (!left_busy && !right_busy) begin
               state_in = gsc_pkg::T_RESULT;
            end
         end
         gsc_pkg::T_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = gsc_pkg::T_IDLE;
            end
         end
         default: state_in = gsc_pkg::T_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = state_ff != gsc_pkg::T_IDLE;
      mem_rd      = 1'b0;
      mem_wr      = 1'b0;
      wr_entry    = rd_entry;
      item_in     = item_ff;
      res_in      = res_ff;
      conn_in     = conn_ff;
      stick_start = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         gsc_pkg::T_IDLE: begin
            mem_rd  = req_valid;
            item_in = req_data;
         end
         gsc_pkg::T_READ: begin
            res_in  = '0;
            conn_in = 1'b0;
            if (in_range) begin
               if (!rd_entry.connected && !rd_entry.countdown[8]) begin
                  mem_wr             = 1'b1;
                  wr_entry.countdown = rd_entry.countdown - 9'd1;
               end else if (!item_ff.link_ok) begin
                  mem_wr              = 1'b1;
                  wr_entry            = '0;
                  wr_entry.countdown  = {1'b0, recheck_ff};
                  res_in.sampled      = 1'b1;
                  res_in.just_removed = was;
               end else begin
                  mem_wr                     = 1'b1;
                  wr_entry.connected         = 1'b1;
                  wr_entry.countdown         = was ? rd_entry.countdown : '0;
                  wr_entry.prev_buttons      = item_ff.raw_buttons;
                  wr_entry.left_held         = lnow;
                  wr_entry.right_held        = rnow;
                  res_in.sampled             = 1'b1;
                  res_in.is_connected        = 1'b1;
                  res_in.just_inserted       = !was;
                  res_in.pressed_edges       = item_ff.raw_buttons &
                     ~(was ? rd_entry.prev_buttons : 16'd0);
                  res_in.left_trigger_flags  = {was && rd_entry.left_held, lnow};
                  res_in.right_trigger_flags = {was && rd_entry.right_held, rnow};
                  conn_in                    = 1'b1;
                  stick_start                = 1'b1;
               end
            end
         end
         gsc_pkg::T_CALC: begin
            mem_wr = 1'b0;
         end
         gsc_pkg::T_RESULT: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            mem_wr = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_next = res_ff;
      if (conn_ff) begin
         rsp_next.left_x_out  = lx;
         rsp_next.left_y_out  = ly;
         rsp_next.right_x_out = rx;
         rsp_next.right_y_out = ry;
         rsp_next.activity    = (lx != '0) || (ly != '0) || (rx != '0) || (ry != '0) ||
                                (item_ff.raw_left_trigger != '0) ||
                                (item_ff.raw_right_trigger != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsc_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
         conn_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         conn_ff  <= conn_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gamepad state conditioner core. Polls go in on
// the request channel; a local per-port predictor works out each result and
// a checker compares every response transfer with the oldest prediction.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gsc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gsc_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [gsc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [gsc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [gsc_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   gamepad_state_conditioner_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor copies of the registers and port state.
   logic [14:0] m_left_dz, m_right_dz;
   logic [7:0] m_trig_thr, m_recheck;
   logic m_dz_en;
   logic m_conn [4];
   int m_count [4];
   logic [15:0] m_prev [4];
   logic m_lheld [4], m_rheld [4];

   gsc_pkg::rsp_type expected_polls [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   function automatic longint root_floor(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] rescale(longint v, longint len, longint d);
      longint mag, q;
      mag = v < 0 ? -v : v;
      q = (32767 * mag * (len - d)) / ((32767 - d) * len);
      if (q > 32767) q = 32767;
      return 16'(v < 0 ? -q : q);
   endfunction

   task automatic radial(input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic [14:0] dz, output logic signed [15:0] xo,
                         output logic signed [15:0] yo);
      longint ax, ay, s, d, len;
      ax = x;
      ay = y;
      s = ax * ax + ay * ay;
      d = longint'(dz);
      if (d >= 32767 || s <= d * d) begin
         xo = '0;
         yo = '0;
      end else begin
         len = root_floor(s);
         xo = rescale(ax, len, d);
         yo = rescale(ay, len, d);
      end
   endtask

   function automatic logic signed [15:0] clip_raw(logic signed [15:0] v);
      return v == gsc_pkg::AXIS_MIN ? gsc_pkg::AXIS_NEG_MAX : v;
   endfunction

   task automatic clear_entry(input int p);
      m_conn[p] = 0;
      m_count[p] = 0;
      m_prev[p] = 0;
      m_lheld[p] = 0;
      m_rheld[p] = 0;
   endtask

   task automatic predict_poll(input gsc_pkg::req_type r);
      gsc_pkg::rsp_type o;
      int p;
      logic lnow, rnow;
      logic signed [15:0] lx, ly, rx, ry;
      o = '0;
      p = int'(r.port);
      if (!m_conn[p] && m_count[p] >= 0) begin
         m_count[p] = m_count[p] - 1;
      end else begin
         o.sampled = 1;
         if (!r.link_ok) begin
            o.just_removed = m_conn[p];
            clear_entry(p);
            m_count[p] = int'(m_recheck);
         end else begin
            if (!m_conn[p]) begin
               clear_entry(p);
               o.just_inserted = 1;
            end
            m_conn[p] = 1;
            o.is_connected = 1;
            if (m_dz_en) begin
               radial(r.raw_left_x, r.raw_left_y, m_left_dz, lx, ly);
               radial(r.raw_right_x, r.raw_right_y, m_right_dz, rx, ry);
            end else begin
               lx = clip_raw(r.raw_left_x);
               ly = clip_raw(r.raw_left_y);
               rx = clip_raw(r.raw_right_x);
               ry = clip_raw(r.raw_right_y);
            end
            o.pressed_edges = r.raw_buttons & ~m_prev[p];
            m_prev[p] = r.raw_buttons;
            lnow = r.raw_left_trigger > m_trig_thr;
            rnow = r.raw_right_trigger > m_trig_thr;
            o.left_trigger_flags = {m_lheld[p], lnow};
            o.right_trigger_flags = {m_rheld[p], rnow};
            m_lheld[p] = lnow;
            m_rheld[p] = rnow;
            o.left_x_out = lx;
            o.left_y_out = ly;
            o.right_x_out = rx;
            o.right_y_out = ry;
            o.activity = (lx != 0) || (ly != 0) || (rx != 0) || (ry != 0) ||
                         (r.raw_left_trigger != 0) || (r.raw_right_trigger != 0);
         end
      end
      expected_polls.push_back(o);
   endtask

   task automatic send_poll(input gsc_pkg::req_type r);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
         @(negedge clock);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_poll(r);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(input gsc_pkg::reg_index_type idx, input logic [31:0] v);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= gsc_pkg::CSR_ADDR_W'(idx) << 2;
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         gsc_pkg::REG_LEFT_DZ: m_left_dz = v[14:0];
         gsc_pkg::REG_RIGHT_DZ: m_right_dz = v[14:0];
         gsc_pkg::REG_TRIG_THR: m_trig_thr = v[7:0];
         gsc_pkg::REG_DZ_EN: m_dz_en = v[0];
         gsc_pkg::REG_RECHECK: m_recheck = v[7:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      while (expected_polls.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
   endtask

   task automatic set_config(input logic [14:0] ldz, input logic [14:0] rdz,
                             input logic [7:0] thr, input logic en,
                             input logic [7:0] rc);
      drain();
      csr_write(gsc_pkg::REG_LEFT_DZ, 32'(ldz));
      csr_write(gsc_pkg::REG_RIGHT_DZ, 32'(rdz));
      csr_write(gsc_pkg::REG_TRIG_THR, 32'(thr));
      csr_write(gsc_pkg::REG_DZ_EN, 32'(en));
      csr_write(gsc_pkg::REG_RECHECK, 32'(rc));
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5, 0))
         0: return gsc_pkg::AXIS_MIN;
         1: return 16'sd32767;
         2: return 16'($urandom_range(20000, 0)) - 16'sd10000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic gsc_pkg::req_type rand_poll(input int p, input logic link);
      gsc_pkg::req_type r;
      r.port = 2'(p);
      r.link_ok = link;
      r.raw_buttons = 16'($urandom);
      r.raw_left_trigger = 8'($urandom);
      r.raw_right_trigger = 8'($urandom);
      r.raw_left_x = rand_axis();
      r.raw_left_y = rand_axis();
      r.raw_right_x = rand_axis();
      r.raw_right_y = rand_axis();
      return r;
   endfunction

   function automatic gsc_pkg::req_type fixed_poll(input int p, input logic link,
                                          input logic [15:0] b, input logic [7:0] t,
                                          input logic signed [15:0] x,
                                          input logic signed [15:0] y);
      gsc_pkg::req_type r;
      r.port = 2'(p);
      r.link_ok = link;
      r.raw_buttons = b;
      r.raw_left_trigger = t;
      r.raw_right_trigger = ~t;
      r.raw_left_x = x;
      r.raw_left_y = y;
      r.raw_right_x = y;
      r.raw_right_y = x;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_polls.size() == 0) begin
            $error("Response transfer with no poll outstanding");
            errors++;
         end else begin
            gsc_pkg::rsp_type e;
            e = expected_polls.pop_front();
            if (rsp_data.sampled !== e.sampled) begin
               $error("sampled exp %0d got %0d", e.sampled, rsp_data.sampled); errors++;
            end
            if (rsp_data.is_connected !== e.is_connected) begin
               $error("is_connected exp %0d got %0d", e.is_connected,
                      rsp_data.is_connected); errors++;
            end
            if (rsp_data.just_inserted !== e.just_inserted) begin
               $error("just_inserted exp %0d got %0d", e.just_inserted,
                      rsp_data.just_inserted); errors++;
            end
            if (rsp_data.just_removed !== e.just_removed) begin
               $error("just_removed exp %0d got %0d", e.just_removed,
                      rsp_data.just_removed); errors++;
            end
            if (rsp_data.pressed_edges !== e.pressed_edges) begin
               $error("pressed_edges exp %h got %h", e.pressed_edges,
                      rsp_data.pressed_edges); errors++;
            end
            if (rsp_data.left_trigger_flags !== e.left_trigger_flags) begin
               $error("left_trigger_flags exp %0d got %0d", e.left_trigger_flags,
                      rsp_data.left_trigger_flags); errors++;
            end
            if (rsp_data.right_trigger_flags !== e.right_trigger_flags) begin
               $error("right_trigger_flags exp %0d got %0d", e.right_trigger_flags,
                      rsp_data.right_trigger_flags); errors++;
            end
            if (rsp_data.left_x_out !== e.left_x_out) begin
               $error("left_x_out exp %0d got %0d", e.left_x_out,
                      rsp_data.left_x_out); errors++;
            end
            if (rsp_data.left_y_out !== e.left_y_out) begin
               $error("left_y_out exp %0d got %0d", e.left_y_out,
                      rsp_data.left_y_out); errors++;
            end
            if (rsp_data.right_x_out !== e.right_x_out) begin
               $error("right_x_out exp %0d got %0d", e.right_x_out,
                      rsp_data.right_x_out); errors++;
            end
            if (rsp_data.right_y_out !== e.right_y_out) begin
               $error("right_y_out exp %0d got %0d", e.right_y_out,
                      rsp_data.right_y_out); errors++;
            end
            if (rsp_data.activity !== e.activity) begin
               $error("activity exp %0d got %0d", e.activity, rsp_data.activity);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct;
      end
   end

   task automatic test_directed;
      // Port 0 starts absent with a zero countdown, so the first poll is skipped.
      send_poll(fixed_poll(0, 1, 16'hFFFF, 8'd255, 16'sd0, 16'sd0));
      send_poll(fixed_poll(0, 1, 16'hFFFF, 8'd255, 16'sd32767, 16'sd0));
      send_poll(fixed_poll(0, 1, 16'hAAAA, 8'd30, gsc_pkg::AXIS_MIN, gsc_pkg::AXIS_MIN));
      send_poll(fixed_poll(0, 1, 16'h5555, 8'd31, 16'sd7849, 16'sd0));
      send_poll(fixed_poll(0, 1, 16'h0000, 8'd0, 16'sd7850, -16'sd1));
      send_poll(fixed_poll(0, 0, 16'hFFFF, 8'd200, 16'sd1000, 16'sd1000));
      repeat (3) send_poll(fixed_poll(0, 1, 16'h1234, 8'd99, 16'sd0, 16'sd0));
      set_config(15'd0, gsc_pkg::DZ_FULL, 8'd0, 1'b1, 8'd0);
      send_poll(fixed_poll(1, 1, 16'h0001, 8'd1, 16'sd0, 16'sd0));
      send_poll(fixed_poll(1, 1, 16'h8000, 8'd1, 16'sd1, -16'sd1));
      send_poll(fixed_poll(1, 1, 16'h8001, 8'd0, gsc_pkg::AXIS_MIN, 16'sd32767));
      send_poll(fixed_poll(1, 0, 16'h0000, 8'd0, 16'sd0, 16'sd0));
      send_poll(fixed_poll(1, 0, 16'h0000, 8'd0, 16'sd0, 16'sd0));
      send_poll(fixed_poll(1, 1, 16'hFFFF, 8'd255, 16'sd5, 16'sd5));
      set_config(15'd32766, 15'd1, 8'd255, 1'b0, 8'd255);
      send_poll(fixed_poll(2, 1, 16'hFFFF, 8'd255, gsc_pkg::AXIS_MIN, 16'sd32767));
      send_poll(fixed_poll(2, 1, 16'h0F0F, 8'd254, 16'sd0, gsc_pkg::AXIS_MIN));
      send_poll(fixed_poll(2, 1, 16'h0000, 8'd0, 16'sd0, 16'sd0));
   endtask

   task automatic test_random(input int count);
      int p;
      repeat (count) begin
         p = int'($urandom_range(3, 0));
         send_poll(rand_poll(p, $urandom_range(9, 0) != 0));
      end
   endtask

   task automatic test_backpressure;
      drain();
      @(posedge clock);
      hold_cycles = 600;
      repeat (12) send_poll(rand_poll(int'($urandom_range(3, 0)), 1'b1));
   endtask

   initial begin
      m_left_dz = gsc_pkg::LEFT_DZ_RESET;
      m_right_dz = gsc_pkg::RIGHT_DZ_RESET;
      m_trig_thr = gsc_pkg::TRIG_THR_RESET;
      m_dz_en = gsc_pkg::DZ_EN_RESET;
      m_recheck = gsc_pkg::RECHECK_RESET;
      for (int i = 0; i < 4; i++) clear_entry(i);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_config(gsc_pkg::LEFT_DZ_RESET, gsc_pkg::RIGHT_DZ_RESET,
                 gsc_pkg::TRIG_THR_RESET, 1'b1, 8'd3);
      send_idle_pct = 24;
      recv_idle_pct = 46;
      test_random(260);
      set_config(15'($urandom_range(32766, 0)), 15'($urandom_range(32766, 0)),
                 8'($urandom_range(255, 0)), 1'b1, 8'd1);
      send_idle_pct = 46;
      recv_idle_pct = 24;
      test_random(260);
      set_config(15'($urandom_range(20000, 0)), 15'($urandom_range(20000, 0)),
                 8'($urandom_range(255, 0)), 1'b0, 8'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(260);
      test_backpressure();
      drain();
      if (errors == 0 && expected_polls.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
